FILE: sv/aip_pkg.sv
// Shared types and constants for the ASCII integer parser.
package aip_pkg;

    // Width of the consumed-byte count reported with each result.
    localparam int OFFSET_BITS = 16;

    typedef struct packed {
        logic [7:0] character;
        logic [5:0] radix;
        logic       last;
    } aip_item_t;

    typedef struct packed {
        logic signed [63:0]       result_value;
        logic [OFFSET_BITS-1:0]   end_offset;
    } aip_result_t;

endpackage

FILE: sv/ascii_integer_parser_core.sv
// Top level of the ASCII integer parser: input register, parse stage and result register.
//
//  Channel  Direction  Handshake                     Payload
//  item     in         item_valid / item_ready       aip_item_t   (one byte per transfer)
//  result   out        result_valid / result_ready   aip_result_t (one per string)
//
// A byte is taken into the input register and then folded into the parse state, where a
// last byte also loads the result register. A new byte can be taken every cycle unless
// the input side is held back; the 64-bit multiply-add of the accumulator by the base is
// the longest path.
// Only a last byte waiting behind an untaken result holds the input side back.
// Reset clears the parse state to the start of a new string and empties both registers.
module ascii_integer_parser_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  aip_pkg::aip_item_t   item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output aip_pkg::aip_result_t result
);
    import aip_pkg::*;

    logic        in_valid_reg;
    aip_item_t   in_item_reg;
    logic        out_valid_reg;
    aip_result_t out_result_reg;
    aip_result_t result_next;
    logic        advance;

    // A byte leaves the input register unless it ends a string and the result slot is full and not being taken.
    assign advance    = in_valid_reg
                        && (!in_item_reg.last || !out_valid_reg || result_ready);
    assign item_ready = !in_valid_reg || advance;

    aip_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .item        (in_item_reg),
        .result_next (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                in_valid_reg <= item_valid;
            end
            if (advance && in_item_reg.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_item_reg <= item;
        end
        if (advance && in_item_reg.last)
        begin
            out_result_reg <= result_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_result_reg;

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> in_valid_reg && in_item_reg.last && out_valid_reg && !result_ready)
        else $error("input stalled without a blocked result");

    a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.last |=> out_valid_reg)
        else $error("last byte processed but no result presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_ready && in_valid_reg && in_item_reg.last |-> !advance)
        else $error("result overwritten before its transfer");

endmodule

FILE: sv/aip_parse.sv
// Parse state machine and per-byte digit accumulation for the ASCII integer parser.
module aip_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  aip_pkg::aip_item_t   item,
    output aip_pkg::aip_result_t result_next
);
    import aip_pkg::*;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_X = 8'h58;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    localparam logic [5:0] BASE_AUTO = 6'd0;
    localparam logic [5:0] BASE_OCT  = 6'd8;
    localparam logic [5:0] BASE_DEC  = 6'd10;
    localparam logic [5:0] BASE_HEX  = 6'd16;

    typedef enum logic [2:0] {
        PH_START,
        PH_SKIP,
        PH_PREFIX,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    phase_t                 phase_reg, phase_next, step_phase;
    logic                   neg_reg, neg_next, step_neg;
    logic [5:0]             base_reg, base_next, step_base;
    logic [63:0]            acc_reg, acc_next, step_acc;
    logic [OFFSET_BITS-1:0] count_reg, count_next;
    logic                   pend_reg, pend_next, step_pend;
    logic [1:0]             step_inc;
    logic [1:0]             total_inc;
    logic                   go;
    logic [7:0]             ch;
    logic                   digit_ok;
    logic [5:0]             digit_val;
    logic [OFFSET_BITS:0]   count_sum;
    logic [OFFSET_BITS-1:0] count_sat;

    assign ch = item.character;

    always_comb
    begin
        digit_ok  = 1'b1;
        digit_val = 6'd0;
        if (ch >= CH_ZERO && ch <= CH_NINE)
        begin
            digit_val = 6'(ch - CH_ZERO);
        end
        else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
        begin
            digit_val = 6'(ch - CH_LOWER_A) + 6'd10;
        end
        else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z)
        begin
            digit_val = 6'(ch - CH_UPPER_A) + 6'd10;
        end
        else
        begin
            digit_ok = 1'b0;
        end
    end

    // One byte walks through the phases in order; go drops once the byte is used up.
    always_comb
    begin
        step_phase = phase_reg;
        step_neg   = neg_reg;
        step_base  = base_reg;
        step_acc   = acc_reg;
        step_pend  = pend_reg;
        step_inc   = 2'd0;
        go         = (phase_reg != PH_DONE);

        if (go && step_phase == PH_START)
        begin
            step_base  = item.radix;
            step_phase = PH_SKIP;
        end

        if (go && step_phase == PH_SKIP)
        begin
            if (ch == CH_SPACE)
            begin
                step_inc = 2'd1;
                go       = 1'b0;
            end
            else
            begin
                step_phase = PH_PREFIX;
                if (ch == CH_MINUS)
                begin
                    step_neg = 1'b1;
                    step_inc = 2'd1;
                    go       = 1'b0;
                end
                else if (ch == CH_PLUS)
                begin
                    step_inc = 2'd1;
                    go       = 1'b0;
                end
            end
        end

        if (go && step_phase == PH_PREFIX)
        begin
            if (step_pend)
            begin
                step_pend = 1'b0;
                if (ch == CH_LOWER_X || ch == CH_UPPER_X)
                begin
                    step_base  = BASE_HEX;
                    step_inc   = 2'd2;
                    step_phase = PH_DIGITS;
                    go         = 1'b0;
                end
                else
                begin
                    // The held zero becomes a digit; the accumulator is still zero.
                    if (step_base == BASE_AUTO)
                    begin
                        step_base = BASE_OCT;
                    end
                    step_inc   = 2'd1;
                    step_phase = PH_DIGITS;
                end
            end
            else if (ch == CH_ZERO && (step_base == BASE_AUTO || step_base == BASE_HEX))
            begin
                step_pend = 1'b1;
                go        = 1'b0;
            end
            else
            begin
                if (step_base == BASE_AUTO)
                begin
                    step_base = BASE_DEC;
                end
                step_phase = PH_DIGITS;
            end
        end

        if (go && step_phase == PH_DIGITS)
        begin
            if (ch == CH_NUL || !digit_ok || digit_val >= step_base)
            begin
                step_phase = PH_DONE;
            end
            else
            begin
                step_acc = acc_reg * {58'd0, step_base} + {58'd0, digit_val};
                step_inc = step_inc + 2'd1;
            end
        end
    end

    // The implied terminator after a last byte only matters when a zero is held.
    assign total_inc = (item.last && step_pend) ? step_inc + 2'd1 : step_inc;
    assign count_sum = {1'b0, count_reg} + (OFFSET_BITS + 1)'(total_inc);
    assign count_sat = count_sum[OFFSET_BITS] ? {OFFSET_BITS{1'b1}}
                                              : count_sum[OFFSET_BITS-1:0];

    assign result_next.result_value = $signed(step_neg ? (64'd0 - step_acc) : step_acc);
    assign result_next.end_offset   = count_sat;

    always_comb
    begin
        if (item.last)
        begin
            phase_next = PH_START;
            neg_next   = 1'b0;
            base_next  = BASE_AUTO;
            acc_next   = 64'd0;
            count_next = '0;
            pend_next  = 1'b0;
        end
        else
        begin
            phase_next = step_phase;
            neg_next   = step_neg;
            base_next  = step_base;
            acc_next   = step_acc;
            count_next = count_sat;
            pend_next  = step_pend;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            neg_reg   <= 1'b0;
            base_reg  <= BASE_AUTO;
            acc_reg   <= 64'd0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            base_reg  <= base_next;
            acc_reg   <= acc_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_START |-> acc_reg == 64'd0 && !neg_reg && !pend_reg
                                  && count_reg == '0)
        else $error("parser start state carries stale data");

    a_pend_in_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> phase_reg == PH_PREFIX && acc_reg == 64'd0)
        else $error("held zero outside the prefix phase");

    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.last |=> phase_reg == PH_START)
        else $error("parser did not restart after the last byte");

endmodule
